// File: sv/stbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table binary search package
// Shared codes, field widths and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int KEY_W             = 32;
    localparam int ACTION_W          = 2;
    localparam int STATUS_W          = 3;
    localparam int POS_W             = 7;
    localparam int TABLE_DEPTH_DEF   = 128;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic probe;
        logic compare;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_search;
        logic range_empty;
        logic key_equal;
    } t_dp_sts;

endpackage

// File: sv/stbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/stbs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table binary search controller
// Sequences one transaction at a time: decode, probe/compare loop, result.
// ----------------------------------------------------------------------------
module stbs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    input  stbs_pkg::t_dp_sts i_sts,
    output stbs_pkg::t_dp_cmd o_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PROBE,
        S_COMPARE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;
    logic   w_accept;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.is_search ? S_PROBE : S_DONE;
            end
            S_PROBE: begin
                // An empty range ends the search; otherwise the middle entry is read.
                o_cmd.probe = 1'b1;
                n_state     = i_sts.range_empty ? S_DONE : S_COMPARE;
            end
            S_COMPARE: begin
                o_cmd.compare = 1'b1;
                n_state       = i_sts.key_equal ? S_DONE : S_PROBE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: sv/stbs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table binary search datapath
// Key table, entry count, search range and the result registers.
// ----------------------------------------------------------------------------
module stbs_dp #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  stbs_pkg::t_dp_cmd                   i_cmd,
    input  logic [stbs_pkg::ACTION_W-1:0]       i_action,
    input  logic signed [stbs_pkg::KEY_W-1:0]   i_key_value,
    output stbs_pkg::t_dp_sts                   o_sts,
    output logic [stbs_pkg::STATUS_W-1:0]       o_status,
    output logic [stbs_pkg::POS_W-1:0]          o_position
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = CW + 1;

    logic [stbs_pkg::ACTION_W-1:0]     r_action;
    logic signed [stbs_pkg::KEY_W-1:0] r_key;
    logic [CW-1:0]                     r_count;
    logic [CW-1:0]                     r_lo;
    logic [CW-1:0]                     r_hi;
    logic [AW-1:0]                     r_mid;
    logic [stbs_pkg::STATUS_W-1:0]     r_status;
    logic [stbs_pkg::POS_W-1:0]        r_pos;
    logic [stbs_pkg::STATUS_W-1:0]     r_out_status;
    logic [stbs_pkg::POS_W-1:0]        r_out_position;

    logic [SW-1:0]                     w_sum;
    logic [AW-1:0]                     w_mid;
    logic                              w_full;
    logic                              w_wr_en;
    logic [stbs_pkg::KEY_W-1:0]        w_rd_data;
    logic signed [stbs_pkg::KEY_W-1:0] w_probe;

    // The range is [lo, hi), so the middle is floor((lo + hi - 1) / 2).
    assign w_sum   = SW'(r_lo) + SW'(r_hi) - SW'(1);
    assign w_mid   = w_sum[AW:1];
    assign w_full  = (r_count == CW'(TABLE_DEPTH));
    assign w_wr_en = i_cmd.exec && (r_action == stbs_pkg::ACT_APPEND) && !w_full;
    assign w_probe = $signed(w_rd_data);

    stbs_ram #(
        .DATA_W (stbs_pkg::KEY_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_key_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (r_key),
        .i_rd_en   (i_cmd.probe),
        .i_rd_addr (w_mid),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if (w_wr_en) begin
                r_count <= r_count + CW'(1);
            end else if (r_action == stbs_pkg::ACT_CLEAR) begin
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action <= i_action;
            r_key    <= i_key_value;
        end
        if (i_cmd.exec) begin
            r_lo  <= '0;
            r_hi  <= r_count;
            r_pos <= '0;
            unique case (r_action)
                stbs_pkg::ACT_APPEND: r_status <= w_full ? stbs_pkg::ST_FULL
                                                         : stbs_pkg::ST_APPENDED;
                stbs_pkg::ACT_CLEAR:  r_status <= stbs_pkg::ST_CLEARED;
                default:              r_status <= stbs_pkg::ST_NOTFOUND;
            endcase
        end
        if (i_cmd.probe) begin
            r_mid <= w_mid;
        end
        if (i_cmd.compare) begin
            if (w_probe == r_key) begin
                r_status <= stbs_pkg::ST_FOUND;
                r_pos    <= stbs_pkg::POS_W'(r_mid);
            end else if (w_probe < r_key) begin
                r_lo <= CW'(r_mid) + CW'(1);
            end else begin
                r_hi <= CW'(r_mid);
            end
        end
        if (i_cmd.load_out) begin
            r_out_status   <= r_status;
            r_out_position <= r_pos;
        end
    end

    assign o_sts.is_search   = (r_action == stbs_pkg::ACT_SEARCH);
    assign o_sts.range_empty = !(r_lo < r_hi);
    assign o_sts.key_equal   = (w_probe == r_key);
    assign o_status          = r_out_status;
    assign o_position        = r_out_position;

endmodule

// File: sv/sorted_table_binary_search.sv
`timescale 1ns / 1ps
// Append, clear and unused codes go from S_EXEC straight to S_DONE; a search makes at most
// floor(log2(count)) + 1 probes (8 at 128), each reading the middle entry in S_PROBE and
// comparing it in S_COMPARE. A search that does not find the key ends in S_PROBE.
// One transaction is in work at a time; the next is accepted the cycle after the
// result enters the output register, which holds it while the output is stalled.
// Synchronous active-low reset empties the table count; table contents are not cleared.
// ----------------------------------------------------------------------------
// Sorted table binary search
// Appends keys to a sorted table, clears it, or binary searches it for a key.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [stbs_pkg::ACTION_W-1:0]     i_action,
    input  logic signed [stbs_pkg::KEY_W-1:0] i_key_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [stbs_pkg::STATUS_W-1:0]     o_status,
    output logic [stbs_pkg::POS_W-1:0]        o_position
);

    stbs_pkg::t_dp_cmd w_cmd;
    stbs_pkg::t_dp_sts w_sts;

    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_action    (i_action),
        .i_key_value (i_key_value),
        .o_sts       (w_sts),
        .o_status    (o_status),
        .o_position  (o_position)
    );

    // An accepted transaction blocks the input until its result is registered.
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // Only a found result carries a position.
    a_pos_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != stbs_pkg::ST_FOUND)) |-> (o_position == '0))
        else $error("position set on a result that is not found");

    // A result never appears while the block is idle waiting for input.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid)) |-> ($past(o_in_stall)))
        else $error("result raised without a transaction in work");

    // Result codes stay within the defined set.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= stbs_pkg::ST_CLEARED))
        else $error("undefined result status");

endmodule
